// ===== sv/rdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types and codes for the reversible deque: operation and status
// codes, the cell command and default sizes.
// ----------------------------------------------------------------------------
package rdq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int MODE_W   = 3;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REVERSE    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Command broadcast to every cell of the row.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,     // take left neighbor (push at physical first end)
      CELL_SHIFT_DOWN,   // take right neighbor (pop at physical first end)
      CELL_PUSH_LAST,    // first empty cell takes the pushed word
      CELL_POP_LAST      // last occupied cell empties
   } cell_op_type;

endpackage
`default_nettype wire

// ===== sv/rdq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_cell
// One storage cell of the deque row. Holds a word and an occupied bit and
// trades them with its neighbors as the broadcast command says.
// ----------------------------------------------------------------------------
module rdq_cell #(
   parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  rdq_pkg::cell_op_type      op,
   input  wire  [DATA_WIDTH-1:0]     push_data,
   input  wire                       left_valid,
   input  wire  [DATA_WIDTH-1:0]     left_data,
   input  wire                       right_valid,
   input  wire  [DATA_WIDTH-1:0]     right_data,
   output logic                      valid,
   output logic [DATA_WIDTH-1:0]     data,
   output logic                      last
);
   import rdq_pkg::*;

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (op)
         CELL_HOLD: begin
         end
         CELL_SHIFT_UP: begin
            valid_in = left_valid;
            data_in  = left_data;
         end
         CELL_SHIFT_DOWN: begin
            valid_in = right_valid;
            data_in  = right_data;
         end
         CELL_PUSH_LAST: begin
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               data_in  = push_data;
            end
         end
         CELL_POP_LAST: begin
            if (valid_ff && !right_valid) valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;
   assign last  = valid_ff && !right_valid;

endmodule
`default_nettype wire

// ===== sv/reversible_deque_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// reversible_deque_core
// Bounded deque built as a row of cells packed from the physical first end,
// with a reverse flag that swaps which end is the logical front.
// ----------------------------------------------------------------------------
// An accepted request sets the pending flag, which then sets the result
// strobe; no new request is taken while busy. Busy is high the cycle after
// accept, while the end words are selected from the cell row into the result regs.
// Reset (synchronous): clears count, reverse flag, cell occupied bits and
// the strobe; cell contents are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module reversible_deque_core #(
   parameter int DEPTH      = rdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  wire  [rdq_pkg::MODE_W-1:0]     req_mode,
   input  wire  [rdq_pkg::WORD_W-1:0]     req_data_in,
   output logic                           rsp_strobe,
   output logic [rdq_pkg::WORD_W-1:0]     rsp_front_value,
   output logic [rdq_pkg::WORD_W-1:0]     rsp_back_value,
   output logic [rdq_pkg::COUNT_W-1:0]    rsp_count,
   output logic [rdq_pkg::STATUS_W-1:0]   rsp_status
);
   import rdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic                  accept;
   logic [DATA_WIDTH-1:0] push_word;
   cell_op_type           cmd;

   logic [CW-1:0]         count_ff, count_in;
   logic                  rev_ff, rev_in;
   logic                  pend_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic                  strobe_ff;
   logic [WORD_W-1:0]     front_ff, back_ff;
   logic [COUNT_W-1:0]    rcount_ff;
   logic [STATUS_W-1:0]   rstatus_ff;

   logic                  cell_valid [DEPTH];
   logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
   logic                  cell_last  [DEPTH];

   logic [DATA_WIDTH-1:0] first_word, last_word;
   logic                  front_is_first;

   assign accept    = start && !pend_ff;
   assign push_word = DATA_WIDTH'(req_data_in);
   assign front_is_first = !rev_ff;

   always_comb begin
      cmd       = CELL_HOLD;
      count_in  = count_ff;
      rev_in    = rev_ff;
      status_in = STATUS_OK;
      if (accept) begin
         unique case (req_mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               if (count_ff == CW'(DEPTH)) begin
                  status_in = STATUS_FULL;
               end else begin
                  cmd = ((req_mode == MODE_PUSH_FRONT) == front_is_first) ?
                        CELL_SHIFT_UP : CELL_PUSH_LAST;
                  count_in = count_ff + CW'(1);
               end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
               if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  cmd = ((req_mode == MODE_POP_FRONT) == front_is_first) ?
                        CELL_SHIFT_DOWN : CELL_POP_LAST;
                  count_in = count_ff - CW'(1);
               end
            end
            MODE_REVERSE: rev_in = ~rev_ff;
            default: begin
               // peek and unused codes change nothing
            end
         endcase
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic                  lv, rv;
         logic [DATA_WIDTH-1:0] ld, rd;
         if (gi == 0) begin : g_first
            assign lv = 1'b1;
            assign ld = push_word;
         end else begin : g_mid_l
            assign lv = cell_valid[gi-1];
            assign ld = cell_data[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign rv = 1'b0;
            assign rd = '0;
         end else begin : g_mid_r
            assign rv = cell_valid[gi+1];
            assign rd = cell_data[gi+1];
         end
         rdq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (cmd),
            .push_data   (push_word),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (cell_valid[gi]),
            .data        (cell_data[gi]),
            .last        (cell_last[gi])
         );
      end
   endgenerate

   // exactly one cell is flagged last when the row is occupied
   always_comb begin
      first_word = cell_valid[0] ? cell_data[0] : '0;
      last_word  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         last_word = last_word | (cell_last[i] ? cell_data[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rev_ff    <= 1'b0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rev_ff    <= rev_in;
         pend_ff   <= accept;
         strobe_ff <= pend_ff;
      end
      if (accept) status_ff <= status_in;
      if (pend_ff) begin
         front_ff   <= WORD_W'(rev_ff ? last_word : first_word);
         back_ff    <= WORD_W'(rev_ff ? first_word : last_word);
         rcount_ff  <= COUNT_W'(count_ff);
         rstatus_ff <= status_ff;
      end
   end

   assign busy            = pend_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_front_value = front_ff;
   assign rsp_back_value  = back_ff;
   assign rsp_count       = rcount_ff;
   assign rsp_status      = rstatus_ff;

endmodule
`default_nettype wire
